FILE: rtl/core/sdsl_pkg.sv
// shared types, character codes and font table of the status line renderer
`default_nettype none

package sdsl_pkg;

   // field widths
   localparam int MAG_W      = 33;
   localparam int MAX_DIGITS = 10;
   localparam int BCD_W      = MAX_DIGITS * 4;
   localparam int STEP_W     = $clog2(MAG_W + 1);

   // character codes, digits 0..9 use their own value
   localparam logic [4:0] CH_S     = 5'd10;
   localparam logic [4:0] CH_P     = 5'd11;
   localparam logic [4:0] CH_D     = 5'd12;
   localparam logic [4:0] CH_T     = 5'd13;
   localparam logic [4:0] CH_O     = 5'd14;
   localparam logic [4:0] CH_COLON = 5'd15;
   localparam logic [4:0] CH_PLUS  = 5'd16;
   localparam logic [4:0] CH_MINUS = 5'd17;
   localparam logic [4:0] CH_BLANK = 5'd18;

   // status line numbers
   localparam logic [1:0] LINE_SPD  = 2'd0;
   localparam logic [1:0] LINE_POS  = 2'd1;
   localparam logic [1:0] LINE_TSPD = 2'd2;
   localparam logic [1:0] LINE_TPOS = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_TRIM,
      ST_EMIT
   } state_type;

   // operations on the digit converter
   typedef struct packed {
      logic load;
      logic dabble;
      logic pop;
   } bcd_ctrl_type;

   // one character toward the output register
   typedef struct packed {
      logic       load;
      logic [4:0] code;
      logic [2:0] page;
      logic [4:0] index;
      logic       last;
   } char_req_type;

   // label length in characters
   function automatic logic [2:0] label_len(input logic [1:0] line);
      return line[1] ? 3'd5 : 3'd4;
   endfunction

   // label character at a position of the label
   function automatic logic [4:0] label_code(input logic [1:0] line, input logic [2:0] idx);
      logic [4:0] code;
      code = CH_BLANK;
      unique case (line)
         LINE_SPD: begin
            unique case (idx)
               3'd0:    code = CH_S;
               3'd1:    code = CH_P;
               3'd2:    code = CH_D;
               3'd3:    code = CH_COLON;
               default: code = CH_BLANK;
            endcase
         end
         LINE_POS: begin
            unique case (idx)
               3'd0:    code = CH_P;
               3'd1:    code = CH_O;
               3'd2:    code = CH_S;
               3'd3:    code = CH_COLON;
               default: code = CH_BLANK;
            endcase
         end
         LINE_TSPD: begin
            unique case (idx)
               3'd0:    code = CH_T;
               3'd1:    code = CH_S;
               3'd2:    code = CH_P;
               3'd3:    code = CH_D;
               3'd4:    code = CH_COLON;
               default: code = CH_BLANK;
            endcase
         end
         LINE_TPOS: begin
            unique case (idx)
               3'd0:    code = CH_T;
               3'd1:    code = CH_P;
               3'd2:    code = CH_O;
               3'd3:    code = CH_S;
               3'd4:    code = CH_COLON;
               default: code = CH_BLANK;
            endcase
         end
      endcase
      return code;
   endfunction

   // 5x7 font, columns left to right as {c0, c1, c2, c3, c4}, bit 0 top row
   function automatic logic [39:0] font_glyph(input logic [4:0] code);
      logic [39:0] g;
      unique case (code)
         5'd0:     g = {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
         5'd1:     g = {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
         5'd2:     g = {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
         5'd3:     g = {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
         5'd4:     g = {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
         5'd5:     g = {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
         5'd6:     g = {8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30};
         5'd7:     g = {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
         5'd8:     g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
         5'd9:     g = {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
         CH_S:     g = {8'h46, 8'h49, 8'h49, 8'h49, 8'h31};
         CH_P:     g = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h06};
         CH_D:     g = {8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C};
         CH_T:     g = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
         CH_O:     g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
         CH_COLON: g = {8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
         CH_PLUS:  g = {8'h08, 8'h08, 8'h3E, 8'h08, 8'h08};
         CH_MINUS: g = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
         default:  g = 40'd0;
      endcase
      return g;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/sdsl_if.sv
// request and response channel interfaces of the status line renderer
`default_nettype none

interface sdsl_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         line;
   logic signed [31:0] value;

   modport source (output valid, output line, output value, input ready);
   modport sink   (input valid, input line, input value, output ready);
endinterface

interface sdsl_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] page;
   logic [4:0] char_index;
   logic [7:0] glyph_col0;
   logic [7:0] glyph_col1;
   logic [7:0] glyph_col2;
   logic [7:0] glyph_col3;
   logic [7:0] glyph_col4;
   logic       last;

   modport source (output valid, output page, output char_index, output glyph_col0,
                   output glyph_col1, output glyph_col2, output glyph_col3,
                   output glyph_col4, output last, input ready);
   modport sink   (input valid, input page, input char_index, input glyph_col0,
                   input glyph_col1, input glyph_col2, input glyph_col3,
                   input glyph_col4, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sdsl_bcd.sv
// bit-serial binary to bcd converter with a digit shift-out port
`default_nettype none

module sdsl_bcd
   import sdsl_pkg::*;
(
   input  wire logic             clock,
   input  wire bcd_ctrl_type     ctrl,
   input  wire logic [MAG_W-1:0] mag_in,
   output logic [3:0]            top_digit
);

   logic [MAG_W-1:0] mag_ff, mag_in_nx;
   logic [BCD_W-1:0] bcd_ff, bcd_in;
   logic [BCD_W-1:0] bcd_adj;
   logic [MAG_W-1:0] mag_nx;

   // add three to every digit of five or more before the shift
   always_comb begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] >= 4'd5) begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
         end else begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4];
         end
      end
   end

   // next value of the shift registers
   always_comb begin
      bcd_in = bcd_ff;
      mag_nx = mag_ff;
      priority if (ctrl.load) begin
         bcd_in = '0;
         mag_nx = mag_in;
      end else if (ctrl.dabble) begin
         bcd_in = {bcd_adj[BCD_W-2:0], mag_ff[MAG_W-1]};
         mag_nx = {mag_ff[MAG_W-2:0], 1'b0};
      end else if (ctrl.pop) begin
         bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
      end else begin
         bcd_in = bcd_ff;
         mag_nx = mag_ff;
      end
      mag_in_nx = mag_nx;
   end

   always_ff @(posedge clock) begin
      bcd_ff <= bcd_in;
      mag_ff <= mag_in_nx;
   end

   assign top_digit = bcd_ff[BCD_W-1 -: 4];

endmodule

`default_nettype wire

FILE: rtl/core/sdsl_glyph.sv
// font lookup and response output register
`default_nettype none

module sdsl_glyph
   import sdsl_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire char_req_type char_req,
   output logic              out_free,
   sdsl_rsp_if.source        rsp_ch
);

   logic        valid_ff, valid_in;
   logic [39:0] glyph_ff;
   logic [2:0]  page_ff;
   logic [4:0]  index_ff;
   logic        last_ff;

   assign out_free = !valid_ff || rsp_ch.ready;

   // valid flag: set on load, cleared when the transfer completes
   always_comb begin
      valid_in = valid_ff;
      priority if (char_req.load) begin
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      if (char_req.load) begin
         glyph_ff <= font_glyph(char_req.code);
         page_ff  <= char_req.page;
         index_ff <= char_req.index;
         last_ff  <= char_req.last;
      end
   end

   assign rsp_ch.valid      = valid_ff;
   assign rsp_ch.page       = page_ff;
   assign rsp_ch.char_index = index_ff;
   assign rsp_ch.glyph_col0 = glyph_ff[39:32];
   assign rsp_ch.glyph_col1 = glyph_ff[31:24];
   assign rsp_ch.glyph_col2 = glyph_ff[23:16];
   assign rsp_ch.glyph_col3 = glyph_ff[15:8];
   assign rsp_ch.glyph_col4 = glyph_ff[7:0];
   assign rsp_ch.last       = last_ff;

endmodule

`default_nettype wire

FILE: rtl/core/signed_decimal_status_line_renderer_top.sv
// top level of the signed decimal status line renderer
//
//   channel   dir   payload                                   transfer
//   req_ch    in    line[1:0], value[31:0] signed             valid && ready
//   rsp_ch    out   page, char_index, glyph_col0..4, last     valid && ready
//
// a line goes through a load, a conversion (one magnitude bit per cycle
// through the bcd shift register), a trim that drops leading zeros while
// keeping at least one digit, and the emission of LINE_CHARS characters.
// reset is synchronous and clears the sequencer and the output valid flag.
// a stalled response holds the character sequencer; a new request is taken
// once the last character of a line sits in the output register.
`default_nettype none

module signed_decimal_status_line_renderer_top
   import sdsl_pkg::*;
#(
   parameter int LINE_CHARS = 21
) (
   input  wire logic  clock,
   input  wire logic  reset,
   sdsl_req_if.sink   req_ch,
   sdsl_rsp_if.source rsp_ch
);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [4:0]        pos_ff, pos_in;
   logic [3:0]        dleft_ff, dleft_in;
   logic [1:0]        line_ff, line_in;
   logic              neg_ff, neg_in;

   bcd_ctrl_type      bcd_ctrl;
   char_req_type      char_req;
   logic [3:0]        top_digit;
   logic              out_free;
   logic [MAG_W-1:0]  mag_ext;
   logic [MAG_W-1:0]  mag_load;
   logic [2:0]        llen;

   // magnitude at 33 bits so the most negative value stays exact
   assign mag_ext  = {req_ch.value[31], req_ch.value};
   assign mag_load = req_ch.value[31] ? (~mag_ext + MAG_W'(1)) : mag_ext;
   assign llen     = label_len(line_ff);

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         pos_ff   <= '0;
         dleft_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         pos_ff   <= pos_in;
         dleft_ff <= dleft_in;
      end
   end

   always_ff @(posedge clock) begin
      line_ff <= line_in;
      neg_ff  <= neg_in;
   end

   // sequencer: next state and controls
   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      pos_in         = pos_ff;
      dleft_in       = dleft_ff;
      line_in        = line_ff;
      neg_in         = neg_ff;
      req_ch.ready   = 1'b0;
      bcd_ctrl       = '0;
      char_req       = '0;
      char_req.code  = CH_BLANK;
      char_req.page  = {line_ff, 1'b0};
      char_req.index = pos_ff;
      char_req.last  = (pos_ff == 5'(LINE_CHARS - 1));

      unique case (state_ff)
         ST_IDLE: begin
            // no request is taken while reset is held
            req_ch.ready = !reset;
            if (req_ch.valid && !reset) begin
               line_in       = req_ch.line;
               neg_in        = req_ch.value[31];
               bcd_ctrl.load = 1'b1;
               step_in       = '0;
               state_in      = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            bcd_ctrl.dabble = 1'b1;
            step_in         = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(MAG_W - 1)) begin
               dleft_in = 4'(MAX_DIGITS);
               state_in = ST_TRIM;
            end
         end
         ST_TRIM: begin
            // drop leading zeros, keeping at least one digit
            if (top_digit == 4'd0 && dleft_ff > 4'd1) begin
               bcd_ctrl.pop = 1'b1;
               dleft_in     = dleft_ff - 4'd1;
            end else begin
               pos_in   = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               char_req.load = 1'b1;
               priority if (pos_ff < {2'b00, llen}) begin
                  char_req.code = label_code(line_ff, pos_ff[2:0]);
               end else if (pos_ff == {2'b00, llen}) begin
                  char_req.code = neg_ff ? CH_MINUS : CH_PLUS;
               end else if (dleft_ff != 4'd0) begin
                  char_req.code = {1'b0, top_digit};
                  bcd_ctrl.pop  = 1'b1;
                  dleft_in      = dleft_ff - 4'd1;
               end else begin
                  char_req.code = CH_BLANK;
               end
               pos_in = pos_ff + 5'd1;
               if (char_req.last) begin
                  pos_in   = '0;
                  state_in = ST_IDLE;
               end
            end
         end
      endcase
   end

   sdsl_bcd u_bcd (
      .clock     (clock),
      .ctrl      (bcd_ctrl),
      .mag_in    (mag_load),
      .top_digit (top_digit)
   );

   sdsl_glyph u_glyph (
      .clock    (clock),
      .reset    (reset),
      .char_req (char_req),
      .out_free (out_free),
      .rsp_ch   (rsp_ch)
   );

   // a loaded character is offered on the response channel next cycle
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      char_req.load |=> rsp_ch.valid)
      else $error("loaded character not offered");

   // the last character of a line returns the sequencer to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (char_req.load && char_req.last) |=> (state_ff == ST_IDLE))
      else $error("sequencer not idle after last character");

   // a request transfer starts the conversion
   a_req_convert: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff == ST_CONVERT))
      else $error("request transfer did not start conversion");

   // trimming always keeps at least one digit
   a_trim_digits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TRIM) |-> (dleft_ff != 4'd0))
      else $error("digit count lost during trim");

endmodule

`default_nettype wire

FILE: tb/tb_signed_decimal_status_line_renderer_top.sv
// self-checking testbench of the signed decimal status line renderer
`timescale 1ns / 1ps

module tb_signed_decimal_status_line_renderer_top
   import sdsl_pkg::*;
();

   localparam int LINE_LEN   = 21;
   localparam int DRAIN_WAIT = 80;

   // font columns per character code, {c0, c1, c2, c3, c4}
   localparam logic [0:18][39:0] GLYPH_COLS = {
      40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4B_31,
      40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03,
      40'h36_49_49_49_36, 40'h06_49_49_29_1E, 40'h46_49_49_49_31, 40'h7F_09_09_09_06,
      40'h7F_41_41_22_1C, 40'h01_01_7F_01_01, 40'h3E_41_41_41_3E, 40'h00_36_36_00_00,
      40'h08_08_3E_08_08, 40'h08_08_08_08_08, 40'h00_00_00_00_00
   };

   // label characters of each status line
   localparam logic [0:3][0:4][4:0] LABEL_CODES = {
      CH_S, CH_P, CH_D, CH_COLON, CH_BLANK,
      CH_P, CH_O, CH_S, CH_COLON, CH_BLANK,
      CH_T, CH_S, CH_P, CH_D,     CH_COLON,
      CH_T, CH_P, CH_O, CH_S,     CH_COLON
   };

   typedef struct packed {
      logic [2:0]  page;
      logic [4:0]  char_index;
      logic [39:0] cols;
      logic        last;
   } glyph_rec_type;

   logic clock;
   logic reset;

   sdsl_req_if req_ch ();
   sdsl_rsp_if rsp_ch ();

   signed_decimal_status_line_renderer_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   glyph_rec_type pending_glyphs[$];
   int fail_count    = 0;
   int lines_sent    = 0;
   int chars_checked = 0;
   int burst_left    = 0;

   // receiver hold-off request, picked up by the receiver process
   int hold_len = 0;
   int hold_req = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int rx_mode = 0;
   int rx_mode_left = 0;

   always #1 clock = ~clock;

   // build the 21 characters expected for one accepted line
   function automatic void render_line(input logic [1:0] ln, input logic signed [31:0] val);
      logic [4:0]    text [0:LINE_LEN-1];
      logic [3:0]    digits [0:9];
      logic [32:0]   mag;
      int            tlen;
      int            ndig;
      int            lbl_len;
      glyph_rec_type rec;
      for (int i = 0; i < LINE_LEN; i++) text[i] = CH_BLANK;
      mag = val[31] ? ({1'b0, ~val} + 33'd1) : {1'b0, val};
      ndig = 0;
      do begin
         digits[ndig] = 4'(mag % 33'd10);
         mag = mag / 33'd10;
         ndig++;
      end while (mag != 33'd0 && ndig < 10);
      lbl_len = (ln == LINE_TSPD || ln == LINE_TPOS) ? 5 : 4;
      tlen = 0;
      for (int i = 0; i < lbl_len; i++) begin
         text[tlen] = LABEL_CODES[ln][i];
         tlen++;
      end
      text[tlen] = val[31] ? CH_MINUS : CH_PLUS;
      tlen++;
      for (int i = ndig; i > 0; i--) begin
         text[tlen] = {1'b0, digits[i-1]};
         tlen++;
      end
      for (int pos = 0; pos < LINE_LEN; pos++) begin
         rec.page       = {ln, 1'b0};
         rec.char_index = 5'(pos);
         rec.cols       = (text[pos] > CH_BLANK) ? GLYPH_COLS[CH_BLANK] : GLYPH_COLS[text[pos]];
         rec.last       = (pos == LINE_LEN - 1);
         pending_glyphs.push_back(rec);
      end
   endfunction

   task automatic check_field(input string name, input logic [39:0] want,
                              input logic [39:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   // compare each character transfer with the oldest expectation
   always @(posedge clock) begin
      glyph_rec_type exp_rec;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_glyphs.size() == 0) begin
            $error("unexpected character transfer, char_index %0d", rsp_ch.char_index);
            fail_count++;
         end else begin
            exp_rec = pending_glyphs.pop_front();
            chars_checked++;
            check_field("page", exp_rec.page, rsp_ch.page);
            check_field("char_index", exp_rec.char_index, rsp_ch.char_index);
            check_field("glyph_col0", exp_rec.cols[39:32], rsp_ch.glyph_col0);
            check_field("glyph_col1", exp_rec.cols[31:24], rsp_ch.glyph_col1);
            check_field("glyph_col2", exp_rec.cols[23:16], rsp_ch.glyph_col2);
            check_field("glyph_col3", exp_rec.cols[15:8], rsp_ch.glyph_col3);
            check_field("glyph_col4", exp_rec.cols[7:0], rsp_ch.glyph_col4);
            check_field("last", exp_rec.last, rsp_ch.last);
         end
      end
   end

   // receiver stall pattern, with a long hold-off on request
   always @(negedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen = hold_req;
         hold_left = hold_len;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(10, 150);
         end
         rx_mode_left--;
         case (rx_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= 1'($urandom_range(0, 1));
            2: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // offer one line, with bursts and gaps, and predict it once transferred
   task automatic send_line(input logic [1:0] ln, input logic signed [31:0] val);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 6);
         case ($urandom_range(0, 3))
            0: gap = 0;
            1: gap = $urandom_range(20, 80);
            default: gap = $urandom_range(1, 5);
         endcase
         if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_ch.valid = 1'b1;
      req_ch.line  = ln;
      req_ch.value = val;
      do @(posedge clock); while (!req_ch.ready);
      render_line(ln, val);
      lines_sent++;
      burst_left--;
      @(negedge clock);
   endtask

   // sender stops until every expected character has come back
   task automatic wait_drain();
      req_ch.valid = 1'b0;
      while (pending_glyphs.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic signed [31:0] pick_value();
      int k;
      int p;
      p = 1;
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $signed($urandom_range(0, 200)) - 100;
         2: begin
            k = $urandom_range(0, 9);
            for (int i = 0; i < k; i++) p = p * 10;
            p = p - $urandom_range(0, 1);
            return $urandom_range(0, 1) ? -p : p;
         end
         3: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         default: return $signed($urandom_range(0, 99999)) * ($urandom_range(0, 1) ? -1 : 1);
      endcase
   endfunction

   // every label with a few small values
   task automatic test_each_line();
      send_line(LINE_SPD, 0);
      send_line(LINE_POS, 7);
      send_line(LINE_TSPD, -3);
      send_line(LINE_TPOS, 42);
      send_line(LINE_SPD, -1);
      send_line(LINE_POS, 1);
      send_line(LINE_TSPD, 0);
      send_line(LINE_TPOS, -12345);
      wait_drain();
   endtask

   // value extremes and digit count boundaries
   task automatic test_extremes();
      send_line(LINE_TPOS, 32'sh7FFF_FFFF);
      send_line(LINE_TSPD, 32'sh8000_0000);
      send_line(LINE_SPD, 32'sh8000_0001);
      send_line(LINE_POS, 9);
      send_line(LINE_SPD, 10);
      send_line(LINE_TPOS, -999999999);
      send_line(LINE_TSPD, 1000000000);
      send_line(LINE_POS, -1000000000);
      send_line(LINE_TPOS, 32'sh5555_5555);
      send_line(LINE_TSPD, 32'shAAAA_AAAA);
      wait_drain();
   endtask

   // long output hold-off while lines keep coming
   task automatic test_backpressure();
      hold_len = 300;
      hold_req++;
      burst_left = 8;
      for (int i = 0; i < 6; i++) send_line(2'($urandom_range(0, 3)), pick_value());
      wait_drain();
   endtask

   // random lines, with one full pause halfway
   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) begin
         send_line(2'($urandom_range(0, 3)), pick_value());
         if (i == count / 2) wait_drain();
      end
      wait_drain();
   endtask

   initial begin
      clock        = 1'b0;
      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.line  = LINE_SPD;
      req_ch.value = '0;
      rsp_ch.ready = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_each_line();
      test_extremes();
      test_backpressure();
      test_random(106);

      // let any stray transfer show up
      repeat (DRAIN_WAIT) @(posedge clock);
      if (pending_glyphs.size() != 0) begin
         $error("%0d expected characters never arrived", pending_glyphs.size());
         fail_count++;
      end
      $display("summary: %0d lines over all four labels, %0d characters compared,",
               lines_sent, chars_checked);
      $display("summary: value extremes, output hold-off and sender pauses included");
      if (fail_count == 0) begin
         $display("PASS signed_decimal_status_line_renderer_top");
      end else begin
         $display("FAIL signed_decimal_status_line_renderer_top");
      end
      $finish;
   end

   // run limit
   initial begin
      #(800_000);
      $display("FAIL signed_decimal_status_line_renderer_top");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/sdsl_pkg.sv
rtl/core/sdsl_if.sv
rtl/core/sdsl_bcd.sv
rtl/core/sdsl_glyph.sv
rtl/core/signed_decimal_status_line_renderer_top.sv
tb/tb_signed_decimal_status_line_renderer_top.sv
